/* src/fmf_pkg.sv */
package fmf_pkg;

   // Largest frame held by one bank
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int BANK_DEPTH = MAX_WIDTH * (2 ** ROW_W);

   localparam int PIX_W      = 24;
   localparam int DIM_W      = 9;
   localparam int MODE_W     = 2;

   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   // Register indexes on the configuration port (byte address / 4)
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FLIP_MODE    = 2'd2;

   // Flip mode bits
   localparam int MODE_HORZ_BIT = 0;
   localparam int MODE_VERT_BIT = 1;

   localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(256);
   localparam logic [MODE_W-1:0] MODE_RESET = '0;

   // Access request to one frame bank
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [PIX_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } bank_req_type;

endpackage

/* src/frame_mirror_flip.sv */
// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   tdata[23:0] pixel_in
// rsp_      out        rsp_tvalid / rsp_tready   tdata[23:0] pixel_out, tlast frame_last
// csr_      in         psel/penable/pwrite/pready  frame_width, frame_height, flip_mode
//
// One item per cycle while rsp_tready stays high and no clearing pass runs; a result
// appears in the cycle after its item is taken, registered in the frame bank read port.
// After reset a clearing pass zeroes every entry of both banks in parallel, one entry
// a cycle, with req_tready low throughout.
// A stalled result holds in the bank read register; req_tready follows rsp_tready
// while a result waits.
module frame_mirror_flip (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fmf_pkg::PIX_W-1:0]     req_tdata,   // [23:0] pixel_in

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fmf_pkg::PIX_W-1:0]     rsp_tdata,   // [23:0] pixel_out
   output logic                          rsp_tlast,   // frame_last

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fmf_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [fmf_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [fmf_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import fmf_pkg::*;

   localparam int CMP_W = ((DIM_W > COL_W) ? DIM_W : COL_W) + 2;
   localparam int CMR_W = ((DIM_W > ROW_W) ? DIM_W : ROW_W) + 2;

   // configuration registers
   logic [DIM_W-1:0]  frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]  frame_height_ff, frame_height_in;
   logic [MODE_W-1:0] flip_mode_ff, flip_mode_in;

   // raster position and bank select
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              wr_bank_ff, wr_bank_in;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic              out_last_ff, out_last_in;
   logic              rd_bank_ff, rd_bank_in;

   logic              csr_write;
   logic [1:0]        csr_index;
   logic              accept;
   logic [COL_W-1:0]  col_last;
   logic [ROW_W-1:0]  row_last;
   logic [COL_W-1:0]  mir_col;
   logic [ROW_W-1:0]  mir_row;
   logic              at_col_end;
   logic              at_row_end;
   bank_req_type      bank0_req, bank1_req;
   logic [PIX_W-1:0]  bank0_data, bank1_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(frame_height_ff);
         REG_FLIP_MODE:    csr_prdata = CSR_DW'(flip_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Last column and line of the active frame: zero reads as one, oversize saturates
   always_comb begin
      if (frame_width_ff == '0) begin
         col_last = '0;
      end else if (CMP_W'(frame_width_ff) > CMP_W'(MAX_WIDTH)) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(CMP_W'(frame_width_ff) - CMP_W'(1));
      end
      if (frame_height_ff == '0) begin
         row_last = '0;
      end else if (CMR_W'(frame_height_ff) > CMR_W'(MAX_HEIGHT)) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(CMR_W'(frame_height_ff) - CMR_W'(1));
      end
   end

   // Mirrored read position in the previous frame
   assign mir_col = flip_mode_ff[MODE_HORZ_BIT] ? (col_last - col_ff) : col_ff;
   assign mir_row = flip_mode_ff[MODE_VERT_BIT] ? (row_last - row_ff) : row_ff;

   assign at_col_end = (col_ff == col_last);
   assign at_row_end = (row_ff == row_last);

   // Take a new item outside the clearing pass when no result waits or the waiting one leaves now
   assign req_tready = ~clearing_ff & (~out_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;

   // Bank accesses: write the raster position of one bank, read the mirror of the other
   always_comb begin
      bank0_req.wr_en   = clearing_ff | (accept & ~wr_bank_ff);
      bank0_req.wr_addr = clearing_ff ? clr_addr_ff : {row_ff, col_ff};
      bank0_req.wr_data = clearing_ff ? '0 : req_tdata;
      bank0_req.rd_en   = accept & wr_bank_ff;
      bank0_req.rd_addr = {mir_row, mir_col};

      bank1_req.wr_en   = clearing_ff | (accept & wr_bank_ff);
      bank1_req.wr_addr = bank0_req.wr_addr;
      bank1_req.wr_data = bank0_req.wr_data;
      bank1_req.rd_en   = accept & ~wr_bank_ff;
      bank1_req.rd_addr = bank0_req.rd_addr;
   end

   fmf_bank u_bank0 (
      .clock    (clock),
      .bank_req (bank0_req),
      .rd_data  (bank0_data)
   );

   fmf_bank u_bank1 (
      .clock    (clock),
      .bank_req (bank1_req),
      .rd_data  (bank1_data)
   );

   // Next-state logic
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      flip_mode_in    = flip_mode_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      wr_bank_in      = wr_bank_ff;
      clearing_in     = clearing_ff;
      clr_addr_in     = clr_addr_ff;
      out_valid_in    = out_valid_ff;
      out_last_in     = out_last_ff;
      rd_bank_in      = rd_bank_ff;

      // advance the clearing pass, stop after the top entry
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end

      // drop the result once taken, then load a new one on accept
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         out_valid_in = 1'b1;
         out_last_in  = at_col_end & at_row_end;
         rd_bank_in   = ~wr_bank_ff;
         if (at_col_end) begin
            col_in = '0;
            if (at_row_end) begin
               row_in     = '0;
               wr_bank_in = ~wr_bank_ff;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      // a size write restarts the frame, bank select kept
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_pwdata[DIM_W-1:0];
               col_in         = '0;
               row_in         = '0;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_pwdata[DIM_W-1:0];
               col_in          = '0;
               row_in          = '0;
            end
            REG_FLIP_MODE: begin
               flip_mode_in = csr_pwdata[MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
         flip_mode_ff    <= MODE_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         wr_bank_ff      <= 1'b0;
         clearing_ff     <= 1'b1;
         clr_addr_ff     <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         flip_mode_ff    <= flip_mode_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         wr_bank_ff      <= wr_bank_in;
         clearing_ff     <= clearing_in;
         clr_addr_ff     <= clr_addr_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // result payload: no reset needed
   always_ff @(posedge clock) begin
      out_last_ff <= out_last_in;
      rd_bank_ff  <= rd_bank_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rd_bank_ff ? bank1_data : bank0_data;
   assign rsp_tlast  = out_last_ff;

endmodule

/* src/fmf_bank.sv */
module fmf_bank (
   input  logic                        clock,
   input  fmf_pkg::bank_req_type       bank_req,
   output logic [fmf_pkg::PIX_W-1:0]   rd_data
);
   import fmf_pkg::*;

   logic [PIX_W-1:0] mem_ff [BANK_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (bank_req.wr_en) begin
         mem_ff[bank_req.wr_addr] <= bank_req.wr_data;
      end
   end

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (bank_req.rd_en) begin
         rd_data_ff <= mem_ff[bank_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fmf_pkg::*;

   // Register 3 is past the end of the map; writes to it must change nothing
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam logic [MODE_W-1:0] FLIP_NONE = 2'd0;
   localparam logic [MODE_W-1:0] FLIP_HORZ = 2'd1;
   localparam logic [MODE_W-1:0] FLIP_VERT = 2'd2;
   localparam logic [MODE_W-1:0] FLIP_BOTH = 2'd3;
   localparam logic [MODE_W-1:0] FLIP_MODES [4] = '{FLIP_NONE, FLIP_HORZ, FLIP_VERT, FLIP_BOTH};

   // Corner values of a pixel: all zero, all one, single low and high bits, stripes, byte masks
   localparam logic [PIX_W-1:0] EDGE_PIX [8] = '{
      24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
      24'hAAAAAA, 24'h555555, 24'h0000FF, 24'hFF0000
   };

   localparam int RAND_ITEMS     = 1676;
   // The clearing pass after reset is the longest correct stretch without an item
   localparam int WATCHDOG_LIMIT = 4 * BANK_DEPTH;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } mirrored_px_type;

   // Frame-delay mirror predictor plus the queue of pixels it has promised
   class mirror_scoreboard;
      bit [PIX_W-1:0]   bank_mem [2][MAX_WIDTH*MAX_HEIGHT];
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      logic [MODE_W-1:0] mode_reg;
      int               col;
      int               row;
      int               wr_bank;
      mirrored_px_type  mirrored_q [$];
      int               errors;

      function new();
         width_reg  = DIM_RESET;
         height_reg = DIM_RESET;
         mode_reg   = MODE_RESET;
         col        = 0;
         row        = 0;
         wr_bank    = 0;
         errors     = 0;
      endfunction

      function int active_dim(logic [DIM_W-1:0] value, int limit);
         if (value == 0) return 1;
         if (int'(value) > limit) return limit;
         return int'(value);
      endfunction

      function void write_reg(logic [1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_FRAME_WIDTH: begin
               width_reg = value[DIM_W-1:0];
               col = 0;
               row = 0;
            end
            REG_FRAME_HEIGHT: begin
               height_reg = value[DIM_W-1:0];
               col = 0;
               row = 0;
            end
            REG_FLIP_MODE: begin
               mode_reg = value[MODE_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pix);
         int              w;
         int              h;
         int              x;
         int              y;
         int              mx;
         int              my;
         mirrored_px_type exp_px;
         w = active_dim(width_reg, MAX_WIDTH);
         h = active_dim(height_reg, MAX_HEIGHT);
         x = (col >= w) ? w - 1 : col;
         y = (row >= h) ? h - 1 : row;
         mx = mode_reg[MODE_HORZ_BIT] ? w - 1 - x : x;
         my = mode_reg[MODE_VERT_BIT] ? h - 1 - y : y;
         exp_px.pixel = bank_mem[wr_bank ^ 1][my*MAX_WIDTH + mx];
         exp_px.last  = (x == w - 1) && (y == h - 1);
         bank_mem[wr_bank][y*MAX_WIDTH + x] = pix;
         mirrored_q.push_back(exp_px);
         if (x + 1 >= w) begin
            col = 0;
            if (y + 1 >= h) begin
               row = 0;
               wr_bank ^= 1;
            end else begin
               row = y + 1;
            end
         end else begin
            col = x + 1;
            row = y;
         end
      endfunction

      function void check_result(logic [PIX_W-1:0] pix, logic last);
         mirrored_px_type exp_px;
         if (mirrored_q.size() == 0) begin
            $error("unexpected result: pixel_out %06h frame_last %b", pix, last);
            errors++;
            return;
         end
         exp_px = mirrored_q.pop_front();
         if (pix !== exp_px.pixel) begin
            $error("pixel_out: expected %06h, got %06h", exp_px.pixel, pix);
            errors++;
         end
         if (last !== exp_px.last) begin
            $error("frame_last: expected %b, got %b", exp_px.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return mirrored_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [PIX_W-1:0]  req_tdata;   // [23:0] pixel_in
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [PIX_W-1:0]  rsp_tdata;   // [23:0] pixel_out
   logic              rsp_tlast;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   mirror_scoreboard sb;
   int               src_idle_pct = 27;
   int               dst_idle_pct = 47;
   int               stall_cycles = 0;

   frame_mirror_flip u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // Sample both channels at the edge; values read here are the ones the block saw
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_pixel(req_tdata);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Stall the result side at random, independent of rsp_tvalid
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
   end

   // Count edges with no item moving on either side; give up past the limit
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Two-phase register write: setup, then access; the register takes it at the
   // edge that ends the access phase; the bus goes idle before the next transfer
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one item after an optional random gap; hold tvalid until it is taken
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop tvalid and wait until every promised pixel has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Mostly random pixels, with a corner value now and then
   function automatic logic [PIX_W-1:0] pick_pixel();
      if ($urandom_range(0, 7) == 0) return EDGE_PIX[$urandom_range(0, 7)];
      return PIX_W'($urandom());
   endfunction

   // Garble the bits above a register's field now and then; the block must drop them
   function automatic logic [CSR_DW-1:0] with_noise(input int value, input logic [CSR_DW-1:0] keep);
      if ($urandom_range(0, 3) == 0) return CSR_DW'(value) | ($urandom() & ~keep);
      return CSR_DW'(value);
   endfunction

   initial begin
      int kind;
      int n;
      int w;
      int h;
      int rand_sent;
      sb = new();
      rand_sent   = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Hold off until the clearing pass is over and the block takes items
      repeat (2) @(posedge clock);
      while (!req_tready) @(posedge clock);

      // 2x2 frames: the first reads the cleared bank, then each mode mirrors the last
      csr_write(REG_FRAME_WIDTH, 2);
      csr_write(REG_FRAME_HEIGHT, 2);
      csr_write(REG_UNUSED, $urandom());
      for (int m = 0; m < 4; m++) begin
         csr_write(REG_FLIP_MODE, CSR_DW'(FLIP_MODES[m]));
         for (int k = 0; k < 4; k++) send_pixel(EDGE_PIX[(4*m + k) % 8]);
         drain();
      end

      // Zero sizes act as 1x1: every item closes a frame and swaps banks
      csr_write(REG_FRAME_WIDTH, 0);
      csr_write(REG_FRAME_HEIGHT, 0);
      send_pixel(EDGE_PIX[1]);
      send_pixel(EDGE_PIX[0]);
      drain();

      // Mode change in the middle of a 3x2 frame
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 2);
      csr_write(REG_FLIP_MODE, CSR_DW'(FLIP_NONE));
      for (int k = 0; k < 4; k++) send_pixel(EDGE_PIX[k + 2]);
      drain();
      csr_write(REG_FLIP_MODE, CSR_DW'(FLIP_BOTH));
      send_pixel(EDGE_PIX[6]);
      send_pixel(EDGE_PIX[7]);
      drain();

      // Random phases: small frames mostly, an occasional full-length line or column,
      // and mode-only writes that land mid-frame
      while (rand_sent < RAND_ITEMS) begin
         kind = $urandom_range(0, 23);
         if (kind == 0) begin
            w = $urandom_range(256, 511);
            csr_write(REG_FRAME_WIDTH, with_noise(w, 32'h1FF));
            csr_write(REG_FRAME_HEIGHT, with_noise($urandom_range(0, 1), 32'h1FF));
            n = MAX_WIDTH;
         end else if (kind == 1) begin
            h = $urandom_range(256, 511);
            csr_write(REG_FRAME_WIDTH, with_noise($urandom_range(0, 1), 32'h1FF));
            csr_write(REG_FRAME_HEIGHT, with_noise(h, 32'h1FF));
            n = MAX_HEIGHT;
         end else if (kind < 8) begin
            n = $urandom_range(1, 12);
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            csr_write(REG_FRAME_WIDTH, with_noise(w, 32'h1FF));
            csr_write(REG_FRAME_HEIGHT, with_noise(h, 32'h1FF));
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 1) n += $urandom_range(0, w*h - 1);
         end
         csr_write(REG_FLIP_MODE, with_noise($urandom_range(0, 3), 32'h3));
         if ($urandom_range(0, 15) == 0) csr_write(REG_UNUSED, $urandom());

         // Receiver-heavy gaps, then sender-heavy, then full rate
         if (rand_sent < RAND_ITEMS / 3) begin
            src_idle_pct = 27;
            dst_idle_pct = 47;
         end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
            src_idle_pct = 47;
            dst_idle_pct = 27;
         end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end

         repeat (n) send_pixel(pick_pixel());
         rand_sent += n;
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
